// ===== rtl/agqp_pkg.sv =====
// Shared types, constants and the gamma table generator for the pixel tone mapper.
package agqp_pkg;

    // Default design parameters.
    localparam int GAMMA_TABLE_BITS_DEF   = 8;
    localparam int MEAN_FRACTION_BITS_DEF = 16;

    // Configuration port layout.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_INVERSE_COUNT = 1'b0;
    localparam logic REG_GAMMA_ENABLE  = 1'b1;
    localparam logic [31:0] INVERSE_COUNT_RESET = 32'h8000_0000;
    localparam logic        GAMMA_ENABLE_RESET  = 1'b1;

    // Unity in Q16, the largest value the gamma curve can take.
    localparam logic [16:0] Q16_ONE = 17'h1_0000;

    // Number of pipeline stages inside one lane.
    localparam int LANE_STAGES = 4;

    // Input beat: accumulated radiance sums of one pixel.
    typedef struct packed {
        logic [31:0] red_sum;
        logic [31:0] green_sum;
        logic [31:0] blue_sum;
        logic        last_pixel;
    } pixel_in_t;

    // Output beat: quantised channels and the packed word.
    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [23:0] packed_pixel;
        logic        last_out;
    } pixel_out_t;

    // Load enables for the lane pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    // Largest y in [0, 65536] with y^11 <= idx^5 * 2^(176 - 5*bits), that is
    // floor(65536 * (idx / 2^bits)^(5/11)). Evaluated only at elaboration.
    function automatic logic [16:0] gamma_knot(input int unsigned idx,
                                               input int unsigned bits);
        logic [191:0] target;
        logic [191:0] pw;
        logic [16:0]  lo;
        logic [16:0]  hi;
        logic [16:0]  mid;
        int           k;
        target = 192'(idx);
        for (k = 0; k < 4; k++) begin
            target = target * 192'(idx);
        end
        target = target << (176 - 5 * bits);
        lo = '0;
        hi = Q16_ONE;
        while (lo < hi) begin
            mid = 17'((18'(lo) + 18'(hi) + 18'd1) >> 1);
            pw  = 192'(1);
            for (k = 0; k < 11; k++) begin
                pw = pw * 192'(mid);
            end
            if (pw <= target) begin
                lo = mid;
            end else begin
                hi = mid - 17'd1;
            end
        end
        return lo;
    endfunction

endpackage

// ===== rtl/agqp_lane.sv =====
// One colour lane: average, clamp, gamma interpolation and 8-bit quantisation.
module agqp_lane
    import agqp_pkg::*;
#(
    parameter int GAMMA_TABLE_BITS   = GAMMA_TABLE_BITS_DEF,
    parameter int MEAN_FRACTION_BITS = MEAN_FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  stage_en_t   stage_en,
    input  logic [31:0] sum,
    input  logic [31:0] inverse_count,
    input  logic        gamma_enable,
    output logic [7:0]  chan_out
);

    localparam int TABLE_ENTRIES = (1 << GAMMA_TABLE_BITS) + 1;
    localparam int IDX_W         = GAMMA_TABLE_BITS + 1;
    localparam int FRAC_W        = 24 - GAMMA_TABLE_BITS;
    localparam int PROD_SHIFT    = 47 - MEAN_FRACTION_BITS;
    localparam int RAW_W         = 64 - PROD_SHIFT;
    localparam int MEAN_W        = MEAN_FRACTION_BITS + 1;
    localparam int M24_W         = 25;
    localparam int MUL_W         = 17 + FRAC_W;
    localparam logic [RAW_W-1:0] MEAN_ONE = RAW_W'(1) << MEAN_FRACTION_BITS;

    typedef logic [TABLE_ENTRIES-1:0][16:0] lut_t;

    function automatic lut_t build_lut();
        lut_t t;
        int   i;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            t[i] = gamma_knot(i, GAMMA_TABLE_BITS);
        end
        return t;
    endfunction

    localparam lut_t GAMMA_LUT = build_lut();

    logic [63:0]       prod_reg;
    logic [63:0]       prod_next;
    logic [16:0]       lin_reg;
    logic [16:0]       lin_next;
    logic [16:0]       base_reg;
    logic [16:0]       base_next;
    logic [16:0]       diff_reg;
    logic [16:0]       diff_next;
    logic [FRAC_W-1:0] frac_reg;
    logic [FRAC_W-1:0] frac_next;
    logic [16:0]       y_reg;
    logic [16:0]       y_next;
    logic [7:0]        chan_reg;
    logic [7:0]        chan_next;

    logic [RAW_W-1:0]  mean_raw;
    logic [MEAN_W-1:0] mean;
    logic [M24_W-1:0]  m24;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  idx_hi;
    logic [16:0]       knot_lo;
    logic [16:0]       knot_hi;
    logic [MUL_W-1:0]  interp_mul;
    logic [24:0]       scaled;

    // Stage one: scale the sum by the reciprocal sample count.
    assign prod_next = 64'(sum) * 64'(inverse_count);

    // Stage two: truncate to the mean, clamp to one and look up the two knots.
    always_comb begin
        mean_raw = prod_reg[63:PROD_SHIFT];
        if (mean_raw > MEAN_ONE) begin
            mean = MEAN_ONE[MEAN_W-1:0];
        end else begin
            mean = mean_raw[MEAN_W-1:0];
        end
        m24    = M24_W'(mean) << (24 - MEAN_FRACTION_BITS);
        idx    = m24[M24_W-1:FRAC_W];
        // At exactly one there is no next knot, so both reads use the last entry.
        idx_hi = idx[IDX_W-1] ? idx : idx + IDX_W'(1);
        knot_lo = GAMMA_LUT[idx];
        knot_hi = GAMMA_LUT[idx_hi];
        lin_next  = m24[M24_W-1:8];
        base_next = knot_lo;
        diff_next = knot_hi - knot_lo;
        frac_next = m24[FRAC_W-1:0];
    end

    // Stage three: linear interpolation between knots, or the linear value.
    always_comb begin
        interp_mul = MUL_W'(diff_reg) * MUL_W'(frac_reg);
        if (gamma_enable) begin
            y_next = base_reg + 17'(interp_mul >> FRAC_W);
        end else begin
            y_next = lin_reg;
        end
    end

    // Stage four: floor(y * 255) in Q16, done as a shift and subtract.
    always_comb begin
        scaled    = {y_reg, 8'd0} - 25'(y_reg);
        chan_next = scaled[23:16];
    end

    // Pipeline registers; each stage holds while it is full and the one after it cannot load.
    always_ff @(posedge aclk) begin
        if (stage_en.s1) begin
            prod_reg <= prod_next;
        end
        if (stage_en.s2) begin
            lin_reg  <= lin_next;
            base_reg <= base_next;
            diff_reg <= diff_next;
            frac_reg <= frac_next;
        end
        if (stage_en.s3) begin
            y_reg <= y_next;
        end
        if (stage_en.s4) begin
            chan_reg <= chan_next;
        end
    end

    assign chan_out = chan_reg;

endmodule

// ===== rtl/agqp_merge.sv =====
// Merging stage: joins the three lanes into one output beat behind a register.
module agqp_merge
    import agqp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic       last,
    output logic       m_valid,
    input  logic       m_ready,
    output pixel_out_t m_data
);

    logic       valid_reg;
    logic       valid_next;
    pixel_out_t data_reg;
    pixel_out_t data_next;

    // The register takes a new beat whenever it is empty or being emptied.
    assign in_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
        data_next.red_out      = red;
        data_next.green_out    = green;
        data_next.blue_out     = blue;
        data_next.packed_pixel = {red, green, blue};
        data_next.last_out     = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== rtl/average_gamma_quantize_pixel.sv =====
// A beat passes lane registers (product, knots, y, channel), then the merge register.
// One pixel per cycle unless stalled; three lanes side by side run the four-stage
// channel pipeline (multiplier, table read, interpolation multiplier, scaling).
// A stall reaches the input in the same cycle through the ready chain; empty stages
// still take new beats. Reset clears all valid flags, sets inverse_count to 1.0 and
// turns gamma on. The gamma table is a constant built at elaboration, so no fill pass.
module average_gamma_quantize_pixel
    import agqp_pkg::*;
#(
    parameter int GAMMA_TABLE_BITS   = GAMMA_TABLE_BITS_DEF,
    parameter int MEAN_FRACTION_BITS = MEAN_FRACTION_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input channel.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_in_t             s_data,
    // Result channel.
    output logic                  m_valid,
    input  logic                  m_ready,
    output pixel_out_t            m_data,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [31:0]            inverse_count_reg;
    logic [31:0]            inverse_count_next;
    logic                   gamma_enable_reg;
    logic                   gamma_enable_next;
    logic                   reg_sel;

    logic [LANE_STAGES-1:0] vld_reg;
    logic [LANE_STAGES-1:0] vld_next;
    logic [LANE_STAGES-1:0] last_reg;
    logic [LANE_STAGES-1:0] last_next;
    logic [LANE_STAGES-1:0] stage_rdy;
    logic                   out_rdy;
    stage_en_t              stage_en;

    logic [7:0]             red_chan;
    logic [7:0]             green_chan;
    logic [7:0]             blue_chan;

    // Register file: word-aligned decode on the single index bit.
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_comb begin
        inverse_count_next = inverse_count_reg;
        gamma_enable_next  = gamma_enable_reg;
        if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_INVERSE_COUNT: inverse_count_next = pwdata[31:0];
                REG_GAMMA_ENABLE:  gamma_enable_next  = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_INVERSE_COUNT: prdata = inverse_count_reg;
            REG_GAMMA_ENABLE:  prdata = {31'd0, gamma_enable_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inverse_count_reg <= INVERSE_COUNT_RESET;
            gamma_enable_reg  <= GAMMA_ENABLE_RESET;
        end else begin
            inverse_count_reg <= inverse_count_next;
            gamma_enable_reg  <= gamma_enable_next;
        end
    end

    // Per-stage ready: a stage loads when it is empty or its successor loads.
    always_comb begin
        stage_rdy[LANE_STAGES-1] = !vld_reg[LANE_STAGES-1] || out_rdy;
        for (int i = LANE_STAGES - 2; i >= 0; i--) begin
            stage_rdy[i] = !vld_reg[i] || stage_rdy[i+1];
        end
    end

    assign s_ready     = stage_rdy[0];
    assign stage_en.s1 = stage_rdy[0];
    assign stage_en.s2 = stage_rdy[1];
    assign stage_en.s3 = stage_rdy[2];
    assign stage_en.s4 = stage_rdy[3];

    // Valid and last-pixel flags travel alongside the lane data.
    always_comb begin
        vld_next  = vld_reg;
        last_next = last_reg;
        if (stage_rdy[0]) begin
            vld_next[0]  = s_valid;
            last_next[0] = s_data.last_pixel;
        end
        for (int i = 1; i < LANE_STAGES; i++) begin
            if (stage_rdy[i]) begin
                vld_next[i]  = vld_reg[i-1];
                last_next[i] = last_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg <= last_next;
    end

    // Three identical lanes, one for each colour channel.
    agqp_lane #(
        .GAMMA_TABLE_BITS   (GAMMA_TABLE_BITS),
        .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
    ) u_lane_red (
        .aclk          (aclk),
        .stage_en      (stage_en),
        .sum           (s_data.red_sum),
        .inverse_count (inverse_count_reg),
        .gamma_enable  (gamma_enable_reg),
        .chan_out      (red_chan)
    );

    agqp_lane #(
        .GAMMA_TABLE_BITS   (GAMMA_TABLE_BITS),
        .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
    ) u_lane_green (
        .aclk          (aclk),
        .stage_en      (stage_en),
        .sum           (s_data.green_sum),
        .inverse_count (inverse_count_reg),
        .gamma_enable  (gamma_enable_reg),
        .chan_out      (green_chan)
    );

    agqp_lane #(
        .GAMMA_TABLE_BITS   (GAMMA_TABLE_BITS),
        .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
    ) u_lane_blue (
        .aclk          (aclk),
        .stage_en      (stage_en),
        .sum           (s_data.blue_sum),
        .inverse_count (inverse_count_reg),
        .gamma_enable  (gamma_enable_reg),
        .chan_out      (blue_chan)
    );

    // Output register that packs the lanes into one beat.
    agqp_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (vld_reg[LANE_STAGES-1]),
        .in_ready (out_rdy),
        .red      (red_chan),
        .green    (green_chan),
        .blue     (blue_chan),
        .last     (last_reg[LANE_STAGES-1]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the pixel tone mapper: average, gamma and 8-bit quantise.
`timescale 1ns / 100ps

module tb_top;
    import agqp_pkg::*;

    localparam int GTB          = GAMMA_TABLE_BITS_DEF;
    localparam int MFB          = MEAN_FRACTION_BITS_DEF;
    localparam int PIPE_LATENCY = 5;
    localparam int MAX_REPORTS  = 10;

    // Byte addresses of the two registers, four bytes apart.
    localparam logic [APB_ADDR_W-1:0] INV_COUNT_ADDR = APB_ADDR_W'(REG_INVERSE_COUNT) << 2;
    localparam logic [APB_ADDR_W-1:0] GAMMA_EN_ADDR  = APB_ADDR_W'(REG_GAMMA_ENABLE) << 2;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_valid  = 1'b0;
    logic                  s_ready;
    pixel_in_t             s_data   = '0;
    logic                  m_valid;
    logic                  m_ready  = 1'b0;
    pixel_out_t            m_data;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state: the register copies and the x^(5/11) knot table.
    logic [31:0] cur_inverse_count = INVERSE_COUNT_RESET;
    logic        cur_gamma_on      = GAMMA_ENABLE_RESET;
    logic [16:0] gamma_curve [0:(1 << GTB)];

    // Pixels accepted by the block whose output beat has not yet arrived.
    pixel_out_t  pending_pixels[$];
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 31;
    int unsigned recv_idle_pct  = 48;

    average_gamma_quantize_pixel dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Knot i is the largest y up to unity with y^11 <= i^5 * 2^(176 - 5*GTB),
    // found bit by bit from the top so that no rounding creeps in.
    function automatic logic [16:0] curve_point(input int unsigned i);
        logic [191:0] bound;
        logic [191:0] power;
        logic [16:0]  y;
        logic [16:0]  cand;
        int           b;
        int           k;
        bound = 192'(i) * 192'(i) * 192'(i) * 192'(i) * 192'(i);
        bound = bound << (176 - 5 * GTB);
        y = '0;
        for (b = 16; b >= 0; b--) begin
            cand = y | (17'd1 << b);
            if (cand <= Q16_ONE) begin
                power = 192'd1;
                for (k = 0; k < 11; k++) begin
                    power = power * 192'(cand);
                end
                if (power <= bound) begin
                    y = cand;
                end
            end
        end
        return y;
    endfunction

    // One channel: scale by the reciprocal, clamp to one, optional gamma, quantise.
    function automatic logic [7:0] tone_map_channel(input logic [31:0] sum);
        logic [63:0] mean;
        logic [63:0] scaled;
        logic [63:0] idx;
        logic [63:0] frac;
        logic [63:0] lo_pt;
        logic [63:0] hi_pt;
        logic [63:0] level;
        mean = ({32'd0, sum} * {32'd0, cur_inverse_count}) >> (47 - MFB);
        if (mean > (64'd1 << MFB)) begin
            mean = 64'd1 << MFB;
        end
        scaled = mean << (24 - MFB);
        if (cur_gamma_on) begin
            idx  = scaled >> (24 - GTB);
            frac = scaled & ((64'd1 << (24 - GTB)) - 64'd1);
            if (idx >= (64'd1 << GTB)) begin
                level = 64'(gamma_curve[1 << GTB]);
            end else begin
                lo_pt = 64'(gamma_curve[idx]);
                hi_pt = 64'(gamma_curve[idx + 1]);
                level = lo_pt + (((hi_pt - lo_pt) * frac) >> (24 - GTB));
            end
        end else begin
            level = scaled >> 8;
        end
        if (level > 64'(Q16_ONE)) begin
            level = 64'(Q16_ONE);
        end
        return 8'((level * 64'd255) >> 16);
    endfunction

    function automatic pixel_out_t predict_pixel(input pixel_in_t px);
        pixel_out_t res;
        res.red_out      = tone_map_channel(px.red_sum);
        res.green_out    = tone_map_channel(px.green_sum);
        res.blue_out     = tone_map_channel(px.blue_sum);
        res.packed_pixel = {res.red_out, res.green_out, res.blue_out};
        res.last_out     = px.last_pixel;
        return res;
    endfunction

    function automatic void note_mismatch(input string what, input logic [23:0] got,
                                          input logic [23:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        end
    endfunction

    function automatic void check_field(input string what, input logic [23:0] got,
                                        input logic [23:0] want);
        if (got !== want) begin
            note_mismatch(what, got, want);
        end
    endfunction

    // Output monitor: every accepted beat is matched against the oldest prediction.
    always @(posedge aclk) begin
        pixel_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                note_mismatch("unexpected output beat", m_data.packed_pixel, 24'd0);
            end else begin
                want = pending_pixels.pop_front();
                check_field("red_out", 24'(m_data.red_out), 24'(want.red_out));
                check_field("green_out", 24'(m_data.green_out), 24'(want.green_out));
                check_field("blue_out", 24'(m_data.blue_out), 24'(want.blue_out));
                check_field("packed_pixel", m_data.packed_pixel, want.packed_pixel);
                check_field("last_out", 24'(m_data.last_out), 24'(want.last_out));
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offers one beat, after a random gap, and records its prediction once accepted.
    task automatic send_pixel(input pixel_in_t px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_pixels.push_back(predict_pixel(px));
    endtask

    task automatic send_rgb(input logic [31:0] r, input logic [31:0] g,
                            input logic [31:0] b, input logic last);
        pixel_in_t px;
        px.red_sum    = r;
        px.green_sum  = g;
        px.blue_sum   = b;
        px.last_pixel = last;
        send_pixel(px);
    endtask

    // Stops offering beats and waits until every predicted beat has come out.
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_LATENCY + 1) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == INV_COUNT_ADDR) begin
            cur_inverse_count = value;
        end else if (addr == GAMMA_EN_ADDR) begin
            cur_gamma_on = value[0];
        end
    endtask

    task automatic apply_setting(input logic [31:0] inv, input logic gamma_on);
        settle_pipeline();
        write_reg(INV_COUNT_ADDR, inv);
        write_reg(GAMMA_EN_ADDR, {31'd0, gamma_on});
    endtask

    // Channel sums: mostly spread over the unclamped range of the current reciprocal
    // and an eighth past it, with some raw words and some right at the saturation point.
    function automatic logic [31:0] random_sum();
        logic [63:0] span;
        span = 64'hFFFF_FFFF;
        if (cur_inverse_count != 32'd0) begin
            span = (64'd1 << (31 + MFB)) / {32'd0, cur_inverse_count};
        end
        case ($urandom_range(9))
            0, 1: return $urandom();
            2: begin
                if (span > 64'hFFFF_FFFE) begin
                    return 32'hFFFF_FFFF;
                end
                return 32'(span) + $urandom_range(2) - 32'd1;
            end
            default: begin
                span = span + (span >> 3);
                if (span > 64'hFFFF_FFFF) begin
                    span = 64'hFFFF_FFFF;
                end
                return $urandom_range(32'(span), 0);
            end
        endcase
    endfunction

    // Reset values: unity reciprocal with gamma on, so the mean is the sum itself.
    task automatic test_reset_defaults();
        send_rgb(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_rgb(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_rgb(32'h0001_0000, 32'h0000_FFFF, 32'h0001_0001, 1'b0);
        send_rgb(32'h0000_0100, 32'h0000_0001, 32'h0000_0080, 1'b1);
        send_rgb(32'h0000_8000, 32'h0000_C0FF, 32'h0000_7F00, 1'b0);
        send_rgb(32'h5555_5555, 32'hAAAA_AAAA, 32'h00FF_00FF, 1'b1);
        send_rgb(32'h0000_FF00, 32'h0000_00FF, 32'h0000_FFFF, 1'b0);
        send_rgb(32'hAAAA_AAAA, 32'h5555_5555, 32'hFF00_FF00, 1'b0);
    endtask

    // Gamma bypassed: the clamped mean goes straight to quantisation.
    task automatic test_linear_path();
        apply_setting(INVERSE_COUNT_RESET, 1'b0);
        send_rgb(32'h0000_0000, 32'h0000_FFFF, 32'h0001_0000, 1'b1);
        send_rgb(32'h0000_8080, 32'h0000_0101, 32'hFFFF_FFFF, 1'b0);
        send_rgb(32'h0000_01FF, 32'h0000_0100, 32'h0000_00FF, 1'b0);
        apply_setting(32'h8000_0000 / 3, 1'b0);
        send_rgb(32'h0003_0000, 32'h0001_8000, 32'h0002_FFFF, 1'b0);
    endtask

    // A zero reciprocal blanks everything; the largest one saturates early.
    task automatic test_reciprocal_extremes();
        apply_setting(32'h0000_0000, 1'b1);
        send_rgb(32'hFFFF_FFFF, 32'h0001_0000, 32'h1234_5678, 1'b1);
        send_rgb(32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 1'b0);
        apply_setting(32'hFFFF_FFFF, 1'b1);
        send_rgb(32'h0000_8000, 32'h0000_7FFF, 32'h0000_8001, 1'b0);
        send_rgb(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b1);
        send_rgb(32'h0000_4000, 32'h0000_0100, 32'h0000_0080, 1'b0);
        apply_setting(32'hFFFF_FFFF, 1'b0);
        send_rgb(32'h0000_8000, 32'h0000_7FFF, 32'h0000_1234, 1'b1);
    endtask

    // Random pixels in segments, each under a freshly chosen register setting.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned seg_len;
        int unsigned k;
        logic [31:0] inv;
        pixel_in_t   px;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(7))
                0: inv = 32'h0000_0000;
                1: inv = 32'hFFFF_FFFF;
                2: inv = INVERSE_COUNT_RESET;
                3: inv = $urandom();
                default: inv = 32'h8000_0000 / $urandom_range(1024, 1);
            endcase
            apply_setting(inv, 1'($urandom_range(1)));
            seg_len = $urandom_range(140, 60);
            for (k = 0; k < seg_len && sent < n_items; k++) begin
                px.red_sum    = random_sum();
                px.green_sum  = random_sum();
                px.blue_sum   = random_sum();
                px.last_pixel = ($urandom_range(15) == 0);
                send_pixel(px);
                sent++;
            end
        end
    endtask

    initial begin
        int unsigned i;
        for (i = 0; i <= (1 << GTB); i++) begin
            gamma_curve[i] = curve_point(i);
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_linear_path();
        test_reciprocal_extremes();

        test_random_traffic(510);
        send_idle_pct = 48;
        recv_idle_pct = 31;
        test_random_traffic(510);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(510);

        settle_pipeline();
        if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
